[src/byte_stuffing_checksum_framer_assert.svh]
// Assertion macros for the framer checker.
// Each expects signals named clk and rst in the scope of use.
`ifndef BYTE_STUFFING_CHECKSUM_FRAMER_ASSERT_SVH
`define BYTE_STUFFING_CHECKSUM_FRAMER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define BSCF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define BSCF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bscf_pkg.sv]
`default_nettype none

package bscf_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h5C;  // backslash
  localparam logic [7:0] START_BYTE = 8'h24;  // '$'
  localparam logic [7:0] ESC_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] ESC_ONE    = 8'h31;  // '1'

  localparam logic [7:0] FRAME_LENGTH_RESET = 8'd27;
  localparam logic [7:0] FRAME_LENGTH_MIN   = 8'd3;

  // Output queue: four beats, room for two escaped items.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } beat_t;

endpackage

`default_nettype wire

[src/byte_stuffing_checksum_framer.sv]
// Channel  Dir  Fields (low bit up)                Accepted when
// -------  ---  ---------------------------------  ---------------------------
// s_*      in   tdata: data_byte[7:0]              s_tvalid & s_tready
// m_*      out  tdata: out_byte[7:0], tlast:       m_tvalid & m_tready
//               run_last, tuser: frame_done
// cfg_*    in   data: frame_length[7:0]            cfg_valid & cfg_ready
//
// One raw byte is taken per cycle while s_tready is high; its one or two link
// beats are worked out in the same cycle and land in a four-beat output queue.
// s_tready is high while the queue has room for two beats, so input keeps
// flowing while up to two beats wait on a stalled link; an escaped byte costs
// the link an extra beat, which sets the sustained rate when it drains.
// Beats are registered in the queue before they appear on m_*.
// rst (synchronous) empties the queue, clears position and sum, and loads a
// frame length of 27. cfg_ready is always high; the length is sampled per beat.
`default_nettype none

module byte_stuffing_checksum_framer (
  input  wire logic       clk,
  input  wire logic       rst,
  // raw frame bytes
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  // framed link stream
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // run_last
  output logic            m_tuser,   // [0] frame_done
  // frame length register
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data   // [7:0] frame_length
);

  logic [7:0] frame_length;
  logic [7:0] byte_position;
  logic [7:0] running_sum;

  bscf_pkg::beat_t                   queue [bscf_pkg::QUEUE_DEPTH];
  logic [bscf_pkg::PTR_W-1:0]        wptr;
  logic [bscf_pkg::PTR_W-1:0]        rptr;
  logic [bscf_pkg::CNT_W-1:0]        count;
  logic [bscf_pkg::CNT_W-1:0]        count_next;

  logic       in_acc;
  logic       out_acc;
  logic [7:0] len;
  logic       final_pos;
  logic       start_pos;
  logic       sum_pos;
  logic [7:0] tx_byte;
  logic       esc;
  bscf_pkg::beat_t beat0;
  bscf_pkg::beat_t beat1;

  assign cfg_ready = 1'b1;

  // Room for the worst case of two beats.
  assign s_tready = (count <= bscf_pkg::CNT_W'(bscf_pkg::QUEUE_DEPTH - 2));
  assign in_acc   = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign out_acc  = m_tvalid && m_tready;

  assign m_tdata = queue[rptr].out_byte;
  assign m_tlast = queue[rptr].run_last;
  assign m_tuser = queue[rptr].frame_done;

  // Frame position decode. Short lengths act as three; a position at or past
  // the end byte (length lowered mid-frame) is taken as the end byte.
  always_comb begin
    len       = (frame_length < bscf_pkg::FRAME_LENGTH_MIN) ?
                bscf_pkg::FRAME_LENGTH_MIN : frame_length;
    final_pos = (byte_position >= len - 8'd1);
    start_pos = !final_pos && (byte_position == 8'd0);
    sum_pos   = !final_pos && (byte_position == len - 8'd2);
    tx_byte   = sum_pos ? (running_sum - 8'd1) : s_tdata;
    // Start mark goes out as is; everything else is stuffed.
    esc       = !start_pos &&
                ((tx_byte == bscf_pkg::ESC_BYTE) || (tx_byte == bscf_pkg::START_BYTE));

    beat0.out_byte   = esc ? bscf_pkg::ESC_BYTE : tx_byte;
    beat0.run_last   = !esc;
    beat0.frame_done = final_pos;
    beat1.out_byte   = (tx_byte == bscf_pkg::ESC_BYTE) ? bscf_pkg::ESC_ZERO
                                                       : bscf_pkg::ESC_ONE;
    beat1.run_last   = 1'b1;
    beat1.frame_done = final_pos;

    count_next = count;
    if (in_acc) begin
      count_next = count_next + (esc ? bscf_pkg::CNT_W'(2) : bscf_pkg::CNT_W'(1));
    end
    if (out_acc) begin
      count_next = count_next - bscf_pkg::CNT_W'(1);
    end
  end

  // Frame state and length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= bscf_pkg::FRAME_LENGTH_RESET;
      byte_position <= 8'd0;
      running_sum   <= 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_length <= cfg_data;
      end
      if (in_acc) begin
        if (final_pos) begin
          byte_position <= 8'd0;
        end else begin
          byte_position <= byte_position + 8'd1;
        end
        // Clear on the start mark, accumulate payload, hold over the slot and end byte.
        if (start_pos) begin
          running_sum <= 8'd0;
        end else if (!final_pos && !sum_pos) begin
          running_sum <= running_sum + s_tdata;
        end
      end
    end
  end

  // Queue pointers and fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        wptr <= wptr + (esc ? bscf_pkg::PTR_W'(2) : bscf_pkg::PTR_W'(1));
      end
      if (out_acc) begin
        rptr <= rptr + bscf_pkg::PTR_W'(1);
      end
    end
  end

  // Queue payload: write one or two beats per accepted input.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      queue[wptr] <= beat0;
      if (esc) begin
        queue[wptr + bscf_pkg::PTR_W'(1)] <= beat1;
      end
    end
  end

endmodule

`default_nettype wire

[src/bscf_checker.sv]
`default_nettype none
`include "byte_stuffing_checksum_framer_assert.svh"

module bscf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  // Hold the beat while the link stalls.
  `BSCF_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output beat changed under stall")

  // A beat that is not the last of its byte is always the escape byte.
  `BSCF_ASSERT_IMP(a_first_is_esc, m_tvalid && !m_tlast, m_tdata == bscf_pkg::ESC_BYTE, "non-final beat is not the escape byte")

  // The escape is followed at once by its code beat, closing the pair.
  `BSCF_ASSERT_NXT(a_pair_code, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast && ((m_tdata == bscf_pkg::ESC_ZERO) || (m_tdata == bscf_pkg::ESC_ONE)), "escape not followed by its code beat")

  // Both beats of a pair carry the same frame_done.
  `BSCF_ASSERT_NXT(a_pair_done, m_tvalid && m_tready && !m_tlast, m_tuser == $past(m_tuser), "frame_done differs within an escape pair")

endmodule

bind byte_stuffing_checksum_framer bscf_checker u_bscf_checker (.*);

`default_nettype wire
